>>> sv/assert_macros.svh
// Assertion macros for the RTL files; the top-level core is the one that includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define AFW_ASSERT(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Antecedent at one edge implies consequent at the next edge.
`define AFW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/afw_pkg.sv
// Package: widths, codes, state type and window table math for the framing core.
package afw_pkg;

  localparam int FRAME_MAX_DEF = 64;
  localparam int FFT_MAX_DEF   = 64;
  localparam int COS_DEPTH_DEF = 256;

  localparam int SAMPLE_W   = 16;
  localparam int KIND_W     = 2;
  localparam int VALUE_W    = 18;
  localparam int INDEX_W    = 6;
  localparam int FL_W       = 7;
  localparam int HOP_W      = 12;
  localparam int FFT_W      = 7;
  localparam int GAIN_W     = 16;
  localparam int COEF_W     = 16;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = 52;
  localparam int WIN_W   = 17;

  localparam int VALUE_MAX = 131071;
  localparam int VALUE_MIN = -131072;

  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE     = 2'd0,
    KIND_SAMPLE_END = 2'd1,
    KIND_END        = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_LEN  = 3'd0,
    CFG_HOP_LEN    = 3'd1,
    CFG_FFT_LEN    = 3'd2,
    CFG_PAD_MODE   = 3'd3,
    CFG_GAIN       = 3'd4,
    CFG_EMPH_COEF  = 3'd5,
    CFG_WIN_MODE   = 3'd6,
    CFG_FLUSH_MODE = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCALE,
    S_SCALE_WB,
    S_CHECK,
    S_ELEM,
    S_RDX,
    S_RDP,
    S_MUL1,
    S_MUL1W,
    S_WDIV,
    S_MUL2,
    S_MUL2W,
    S_OUT,
    S_POST
  } state_t;

  // Taylor cosine on [0, pi/2], Q30 in and out, clamped to [0, 1].
  function automatic longint cos_q30(input longint theta);
    longint t2;
    longint r;
    t2 = (theta * theta) / Q30_ONE;
    r  = Q30_ONE - t2 / 90;
    r  = Q30_ONE - ((t2 * r) / Q30_ONE) / 56;
    r  = Q30_ONE - ((t2 * r) / Q30_ONE) / 30;
    r  = Q30_ONE - ((t2 * r) / Q30_ONE) / 12;
    r  = Q30_ONE - ((t2 * r) / Q30_ONE) / 2;
    if (r < 0) r = 0;
    if (r > Q30_ONE) r = Q30_ONE;
    return r;
  endfunction

  // Hann weight in Q15 for quadrant quad and in-quadrant angle theta (Q30).
  function automatic longint hann_q15(input longint quad, input longint theta);
    longint c;
    longint s;
    longint cv;
    longint h;
    c = cos_q30(theta);
    s = cos_q30(HALF_PI_Q30 - theta);
    case (quad)
      0:       cv = c;
      1:       cv = -s;
      2:       cv = -c;
      default: cv = s;
    endcase
    h = (Q30_ONE - cv) / 2;
    return (h + 16384) >>> 15;
  endfunction

endpackage

>>> sv/afw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module afw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/afw_mul.sv
// Shared signed multiplier with registered product.
module afw_mul (
  input  logic                               clk,
  input  logic signed [afw_pkg::MUL_A_W-1:0] a,
  input  logic signed [afw_pkg::MUL_B_W-1:0] b,
  output logic signed [afw_pkg::MUL_P_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= afw_pkg::MUL_P_W'(a * b);
  end

endmodule

>>> sv/afw_div.sv
// Restoring divider, one quotient bit per cycle.
module afw_div #(
  parameter int DW = 16,
  parameter int NW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo;
  logic [NW-1:0] rem;
  logic [NW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [NW:0]   rem_sh;
  logic [NW:0]   trial;
  logic          fits;

  always_comb begin
    rem_sh = {rem, quo[DW-1]};
    trial  = rem_sh - {1'b0, dvs};
    fits   = (rem_sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CW'(DW);
      quo  <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      rem <= fits ? trial[NW-1:0] : rem_sh[NW-1:0];
      quo <= {quo[DW-2:0], fits};
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quotient = quo;

endmodule

>>> sv/afw_win_rom.sv
// Hann weight table over one cosine period, built at elaboration.
module afw_win_rom #(
  parameter int DEPTH = 256
) (
  input  logic [$clog2(DEPTH)-1:0]    k,
  output logic [afw_pkg::WIN_W-1:0]   w
);

  logic [afw_pkg::WIN_W-1:0] rom [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_entry
    localparam longint M     = 4 * g;
    localparam longint QUAD  = M / DEPTH;
    localparam longint REM   = M % DEPTH;
    localparam longint THETA = REM * afw_pkg::HALF_PI_Q30 / DEPTH;
    assign rom[g] = afw_pkg::WIN_W'(afw_pkg::hann_q15(QUAD, THETA));
  end

  assign w = rom[k];

endmodule

>>> sv/audio_frame_window_preprocess_core.sv
// Top level of the speech framing core: scale, frame, pre-emphasis, Hann window, pad.
// Scaled PCM samples go into a circular store of FRAME_MAX entries. Every hop_length
// samples a frame of the last frame_length samples goes out as out_length transfers
// (value, index, tlast on the final one), pre-emphasized, Hann windowed and zero padded
// or trimmed, left-aligned or centered. A chunk end with a partly filled queue sends a
// zero-padded partial frame unless buffering is on, then framing restarts, optionally
// semicausally. Timing: the input side takes one item, then is busy while the sample is
// scaled and stored, and for a chunk end also while the flush check runs. For each
// in-range element of a frame the store is read, the shared restoring divider turns the
// element position into a cosine table index one quotient bit per cycle (DW, the
// window-index dividend width, is 15 at the default sizes) and the two products are
// formed; trimmed-off or pad positions skip these steps. Each frame closes with a post step.
// One multiplier serves input scaling, pre-emphasis and windowing in turn. There is no
// clearing pass after reset or flush: a count of samples written since the last clear
// makes stale store entries read as zero. Output stalls only hold the sequencer.
`include "assert_macros.svh"

module audio_frame_window_preprocess_core #(
  parameter int FRAME_MAX       = afw_pkg::FRAME_MAX_DEF,
  parameter int FFT_MAX         = afw_pkg::FFT_MAX_DEF,
  parameter int COS_TABLE_DEPTH = afw_pkg::COS_DEPTH_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst,
  // input stream
  input  logic                                            s_tvalid,
  output logic                                            s_tready,
  input  logic [afw_pkg::SAMPLE_W-1:0]                    s_tdata,  // [15:0] sample
  input  logic [afw_pkg::KIND_W-1:0]                      s_tuser,  // [1:0] kind
  // output stream
  output logic                                            m_tvalid,
  input  logic                                            m_tready,
  output logic [afw_pkg::VALUE_W+afw_pkg::INDEX_W-1:0]    m_tdata,  // [17:0] value, [23:18] index
  output logic                                            m_tlast,  // frame_last
  // configuration writes
  input  logic                                            cfg_we,
  input  logic [afw_pkg::CFG_IDX_W-1:0]                   cfg_index,
  input  logic [afw_pkg::CFG_DATA_W-1:0]                  cfg_data
);

  localparam int AW      = $clog2(FRAME_MAX);
  localparam int LW      = $clog2(FRAME_MAX + 1);
  localparam int FW      = $clog2(FFT_MAX + 1);
  localparam int KW      = $clog2(COS_TABLE_DEPTH);
  localparam int DW      = $clog2((2 * FRAME_MAX - 1) * COS_TABLE_DEPTH + FRAME_MAX + 1);
  localparam int NW      = $clog2(2 * FRAME_MAX + 1);
  localparam int SW      = ((LW > FW) ? LW : FW) + 2;
  localparam int RST_LEN = (64 > FRAME_MAX) ? FRAME_MAX : 64;

  // ---------------- configuration registers ----------------
  logic [afw_pkg::FL_W-1:0]   frame_length;
  logic [afw_pkg::HOP_W-1:0]  hop_length;
  logic [afw_pkg::FFT_W-1:0]  out_length;
  logic                       padding_mode;
  logic [afw_pkg::GAIN_W-1:0] input_gain;
  logic [afw_pkg::COEF_W-1:0] emphasis_coef;
  logic [afw_pkg::MODE_W-1:0] window_mode;
  logic [afw_pkg::MODE_W-1:0] flush_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length  <= afw_pkg::FL_W'(64);
      hop_length    <= afw_pkg::HOP_W'(32);
      out_length    <= afw_pkg::FFT_W'(64);
      padding_mode  <= 1'b0;
      input_gain    <= afw_pkg::GAIN_W'(4096);
      emphasis_coef <= '0;
      window_mode   <= '0;
      flush_mode    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        afw_pkg::CFG_FRAME_LEN:  frame_length  <= cfg_data[afw_pkg::FL_W-1:0];
        afw_pkg::CFG_HOP_LEN:    hop_length    <= cfg_data[afw_pkg::HOP_W-1:0];
        afw_pkg::CFG_FFT_LEN:    out_length    <= cfg_data[afw_pkg::FFT_W-1:0];
        afw_pkg::CFG_PAD_MODE:   padding_mode  <= cfg_data[0];
        afw_pkg::CFG_GAIN:       input_gain    <= cfg_data[afw_pkg::GAIN_W-1:0];
        afw_pkg::CFG_EMPH_COEF:  emphasis_coef <= cfg_data[afw_pkg::COEF_W-1:0];
        afw_pkg::CFG_WIN_MODE:   window_mode   <= cfg_data[afw_pkg::MODE_W-1:0];
        afw_pkg::CFG_FLUSH_MODE: flush_mode    <= cfg_data[afw_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // effective lengths: zero acts as one, oversize clamps to the store / fft size
  logic [LW-1:0]               len;
  logic [FW-1:0]               fft_eff;
  logic [afw_pkg::HOP_W-1:0]   hop_eff;

  always_comb begin
    if (frame_length == '0) len = LW'(1);
    else if (int'(frame_length) > FRAME_MAX) len = LW'(FRAME_MAX);
    else len = LW'(frame_length);
    if (out_length == '0) fft_eff = FW'(1);
    else if (int'(out_length) > FFT_MAX) fft_eff = FW'(FFT_MAX);
    else fft_eff = FW'(out_length);
    hop_eff = (hop_length == '0) ? afw_pkg::HOP_W'(1) : hop_length;
  end

  // ---------------- sequencer and datapath registers ----------------
  afw_pkg::state_t state, state_next;

  logic [afw_pkg::KIND_W-1:0]          kind_r;
  logic signed [afw_pkg::SAMPLE_W-1:0] sample_r;
  logic [AW-1:0]                       write_pointer;
  logic [LW-1:0]                       fill_count;
  logic [LW-1:0]                       written_count;  // samples since last clear
  logic [afw_pkg::HOP_W-1:0]           steps_to_frame;
  logic [LW-1:0]                       span;
  logic                                flushing;
  logic [FW-1:0]                       i_cnt;
  logic [AW-1:0]                       qx_pos, qp_pos;
  logic                                qx_zero, qp_zero;
  logic                                w_one;
  logic signed [afw_pkg::SAMPLE_W-1:0] x_r;
  logic signed [afw_pkg::MUL_A_W-1:0]  e_r;
  logic [afw_pkg::WIN_W-1:0]           w_r;
  logic signed [afw_pkg::VALUE_W-1:0]  value_r;
  logic signed [afw_pkg::VALUE_W-1:0]  out_value;
  logic [afw_pkg::INDEX_W-1:0]         out_index;
  logic                                out_last;

  // ---------------- shared units ----------------
  logic signed [afw_pkg::MUL_A_W-1:0] mul_a;
  logic signed [afw_pkg::MUL_B_W-1:0] mul_b;
  logic signed [afw_pkg::MUL_P_W-1:0] mul_p;

  afw_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  logic                          ram_we;
  logic [AW-1:0]                 ram_raddr;
  logic [afw_pkg::SAMPLE_W-1:0]  ram_wdata;
  logic [afw_pkg::SAMPLE_W-1:0]  ram_rdata;

  afw_ram #(
    .WIDTH (afw_pkg::SAMPLE_W),
    .DEPTH (FRAME_MAX)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_pointer),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic          div_start;
  logic          div_done;
  logic [DW-1:0] div_dividend;
  logic [NW-1:0] div_divisor;
  logic [DW-1:0] div_q;

  afw_div #(
    .DW (DW),
    .NW (NW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  logic [DW-1:0]             k_wide;
  logic [KW-1:0]             win_k;
  logic [afw_pkg::WIN_W-1:0] win_w;

  // quotient stays below twice the table depth, so one subtract wraps it
  always_comb begin
    k_wide = (div_q >= DW'(COS_TABLE_DEPTH)) ? div_q - DW'(COS_TABLE_DEPTH) : div_q;
    win_k  = k_wide[KW-1:0];
  end

  afw_win_rom #(
    .DEPTH (COS_TABLE_DEPTH)
  ) u_rom (
    .k (win_k),
    .w (win_w)
  );

  // ---------------- element address math ----------------
  // store slot of queue element jj (oldest first) and whether it reads as zero
  function automatic logic [AW:0] q_lookup(input logic [LW-1:0] jj,
                                           input logic [LW-1:0] sp,
                                           input logic [LW-1:0] fc,
                                           input logic [LW-1:0] wr,
                                           input logic [AW-1:0] ptr);
    logic [LW-1:0] age;
    logic [AW:0]   sum;
    logic          zero;
    age  = sp - LW'(1) - jj;
    zero = (jj >= sp) || (age >= fc) || (age >= wr);
    sum  = (AW+1)'(ptr) + (AW+1)'(FRAME_MAX - 1) - (AW+1)'(age);
    if (sum >= (AW+1)'(FRAME_MAX)) sum = sum - (AW+1)'(FRAME_MAX);
    return {zero, sum[AW-1:0]};
  endfunction

  logic signed [SW-1:0] pad_diff, pad_off, src;
  logic                 in_range;
  logic [LW-1:0]        elem_j, elem_jm1, n_win;
  logic [AW:0]          lx, lp;
  logic                 elem_last;
  logic                 out_load;

  always_comb begin
    pad_diff = $signed(SW'(fft_eff)) - $signed(SW'(len));
    // centered offset truncates toward zero
    pad_off  = pad_diff[SW-1] ? -((-pad_diff) >>> 1) : (pad_diff >>> 1);
    src      = padding_mode ? $signed(SW'(i_cnt)) - pad_off : $signed(SW'(i_cnt));
    in_range = !src[SW-1] && (src < $signed(SW'(len)));
    elem_j   = src[LW-1:0];
    elem_jm1 = (elem_j == '0) ? elem_j : elem_j - LW'(1);
    lx       = q_lookup(elem_j, span, fill_count, written_count, write_pointer);
    lp       = q_lookup(elem_jm1, span, fill_count, written_count, write_pointer);
    // periodic window only for even lengths
    n_win    = (window_mode[0] && !len[0]) ? len : len - LW'(1);
    div_dividend = DW'({elem_j, window_mode[1]}) * DW'(COS_TABLE_DEPTH) + DW'(n_win);
    div_divisor  = NW'({n_win, 1'b0});
    elem_last    = (i_cnt == fft_eff - FW'(1));
    out_load     = (state == afw_pkg::S_OUT) && (!m_tvalid || m_tready);
  end

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    case (state)
      afw_pkg::S_IDLE: begin
        if (s_tvalid) begin
          case (s_tuser)
            afw_pkg::KIND_SAMPLE,
            afw_pkg::KIND_SAMPLE_END: state_next = afw_pkg::S_SCALE;
            afw_pkg::KIND_END:        state_next = afw_pkg::S_CHECK;
            default:                  state_next = afw_pkg::S_IDLE;
          endcase
        end
      end
      afw_pkg::S_SCALE: state_next = afw_pkg::S_SCALE_WB;
      afw_pkg::S_SCALE_WB: begin
        if (steps_to_frame <= afw_pkg::HOP_W'(1)) state_next = afw_pkg::S_ELEM;
        else if (kind_r == afw_pkg::KIND_SAMPLE_END) state_next = afw_pkg::S_CHECK;
        else state_next = afw_pkg::S_IDLE;
      end
      afw_pkg::S_CHECK: begin
        if (!flush_mode[0] && fill_count != '0 && fill_count < len) begin
          state_next = afw_pkg::S_ELEM;
        end else begin
          state_next = afw_pkg::S_IDLE;
        end
      end
      afw_pkg::S_ELEM:  state_next = in_range ? afw_pkg::S_RDX : afw_pkg::S_OUT;
      afw_pkg::S_RDX:   state_next = afw_pkg::S_RDP;
      afw_pkg::S_RDP:   state_next = afw_pkg::S_MUL1;
      afw_pkg::S_MUL1:  state_next = afw_pkg::S_MUL1W;
      afw_pkg::S_MUL1W: state_next = afw_pkg::S_WDIV;
      afw_pkg::S_WDIV:  state_next = div_done ? afw_pkg::S_MUL2 : afw_pkg::S_WDIV;
      afw_pkg::S_MUL2:  state_next = afw_pkg::S_MUL2W;
      afw_pkg::S_MUL2W: state_next = afw_pkg::S_OUT;
      afw_pkg::S_OUT: begin
        if (out_load) state_next = elem_last ? afw_pkg::S_POST : afw_pkg::S_ELEM;
      end
      afw_pkg::S_POST:  state_next = afw_pkg::S_IDLE;
      default:          state_next = afw_pkg::S_IDLE;
    endcase
  end

  // ---------------- unit controls ----------------
  always_comb begin
    s_tready  = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = qp_pos;
    div_start = 1'b0;
    mul_a     = $signed(afw_pkg::MUL_A_W'(emphasis_coef));
    mul_b     = (qp_zero) ? '0 : afw_pkg::MUL_B_W'($signed(ram_rdata));
    case (state)
      afw_pkg::S_IDLE:     s_tready = 1'b1;
      afw_pkg::S_SCALE: begin
        mul_a = afw_pkg::MUL_A_W'(sample_r);
        mul_b = $signed(afw_pkg::MUL_B_W'(input_gain));
      end
      afw_pkg::S_SCALE_WB: ram_we = 1'b1;
      afw_pkg::S_ELEM:     div_start = in_range;
      afw_pkg::S_RDX:      ram_raddr = qx_pos;
      afw_pkg::S_MUL2: begin
        mul_a = e_r;
        mul_b = $signed(afw_pkg::MUL_B_W'(w_r));
      end
      default: ;
    endcase
  end

  // scaled sample: round half up, saturate to Q1.15
  logic signed [afw_pkg::MUL_P_W-1:0]  scaled;
  logic signed [afw_pkg::SAMPLE_W-1:0] x_sat;
  // windowed element: round half up from Q.46, saturate to 18 bits
  logic signed [afw_pkg::MUL_P_W-1:0]  rounded;
  logic signed [afw_pkg::VALUE_W-1:0]  v_sat;

  always_comb begin
    scaled = (mul_p + afw_pkg::MUL_P_W'(2048)) >>> 12;
    if (scaled > afw_pkg::MUL_P_W'(32767)) x_sat = 16'sh7FFF;
    else if (scaled < -afw_pkg::MUL_P_W'(32768)) x_sat = 16'sh8000;
    else x_sat = scaled[afw_pkg::SAMPLE_W-1:0];
    rounded = (mul_p + (afw_pkg::MUL_P_W'(1) <<< 30)) >>> 31;
    if (rounded > afw_pkg::MUL_P_W'(afw_pkg::VALUE_MAX)) begin
      v_sat = afw_pkg::VALUE_W'(afw_pkg::VALUE_MAX);
    end else if (rounded < afw_pkg::MUL_P_W'(afw_pkg::VALUE_MIN)) begin
      v_sat = afw_pkg::VALUE_W'(afw_pkg::VALUE_MIN);
    end else begin
      v_sat = rounded[afw_pkg::VALUE_W-1:0];
    end
  end

  assign ram_wdata = x_sat;

  // ---------------- register updates ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= afw_pkg::S_IDLE;
      write_pointer  <= '0;
      fill_count     <= '0;
      written_count  <= '0;
      steps_to_frame <= afw_pkg::HOP_W'(RST_LEN);
      flushing       <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        afw_pkg::S_IDLE: begin
          kind_r   <= s_tuser;
          sample_r <= s_tdata;
        end
        afw_pkg::S_SCALE_WB: begin
          write_pointer <= (write_pointer == AW'(FRAME_MAX - 1)) ?
                           '0 : write_pointer + AW'(1);
          if (fill_count != LW'(FRAME_MAX)) fill_count <= fill_count + LW'(1);
          if (written_count != LW'(FRAME_MAX)) written_count <= written_count + LW'(1);
          if (steps_to_frame <= afw_pkg::HOP_W'(1)) begin
            span     <= len;
            flushing <= 1'b0;
            i_cnt    <= '0;
          end else begin
            steps_to_frame <= steps_to_frame - afw_pkg::HOP_W'(1);
          end
        end
        afw_pkg::S_CHECK: begin
          span     <= fill_count;
          flushing <= 1'b1;
          i_cnt    <= '0;
        end
        afw_pkg::S_ELEM: begin
          qx_zero <= lx[AW];
          qx_pos  <= lx[AW-1:0];
          qp_zero <= lp[AW];
          qp_pos  <= lp[AW-1:0];
          w_one   <= (n_win == '0);
          value_r <= '0;
        end
        afw_pkg::S_RDP:   x_r <= qx_zero ? '0 : ram_rdata;
        afw_pkg::S_MUL1W: begin
          e_r <= (afw_pkg::MUL_A_W'(x_r) <<< 16) - mul_p[afw_pkg::MUL_A_W-1:0];
        end
        afw_pkg::S_WDIV:  w_r <= w_one ? afw_pkg::WIN_W'(32768) : win_w;
        afw_pkg::S_MUL2W: value_r <= v_sat;
        afw_pkg::S_OUT: begin
          if (out_load) begin
            out_value <= value_r;
            out_index <= afw_pkg::INDEX_W'(i_cnt);
            out_last  <= elem_last;
            i_cnt     <= i_cnt + FW'(1);
          end
        end
        afw_pkg::S_POST: begin
          if (flushing) begin
            // store reads as zero from here on: supplies the semicausal prefill
            written_count <= '0;
            if (flush_mode[1] && (int'(hop_eff) < int'(len))) begin
              steps_to_frame <= afw_pkg::HOP_W'(len) - hop_eff;
              fill_count     <= LW'(hop_eff);
            end else begin
              steps_to_frame <= afw_pkg::HOP_W'(len);
              fill_count     <= '0;
            end
          end else begin
            steps_to_frame <= hop_eff;
            if (fill_count > len) fill_count <= len;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_tdata = {out_index, out_value};
  assign m_tlast = out_last;

  // ---------------- assertions ----------------
  `AFW_ASSERT(a_fill_bound, clk, rst, fill_count <= LW'(FRAME_MAX))
  `AFW_ASSERT(a_steps_live, clk, rst, state != afw_pkg::S_IDLE || steps_to_frame != '0)
  `AFW_ASSERT_NEXT(a_last_post, clk, rst, out_load && elem_last, state == afw_pkg::S_POST && m_tvalid && m_tlast)

endmodule
